[sv/smal_pkg.sv]
// Shared types and constants for the servo motion activity LED block.
package smal_pkg;

  localparam int NUM_SERVOS = 5;
  localparam int ANGLE_W    = 8;
  localparam int REG_W      = 16;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

  localparam logic [REG_W-1:0] PRESCALE_RST  = 16'd10;
  localparam logic [REG_W-1:0] HOLD_RST      = 16'd200;
  localparam logic [REG_W-1:0] BLINK_RST     = 16'd25;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd1;

  typedef logic [NUM_SERVOS-1:0][ANGLE_W-1:0] angles_t;

  typedef struct packed {
    logic [REG_W-1:0] prescale;
    logic [REG_W-1:0] hold_checks;
    logic [REG_W-1:0] blink_checks;
    logic [THR_W-1:0] motion_threshold;
  } cfg_t;

endpackage

[sv/smal_if.sv]
// Request channel interfaces: servo angle ticks in, LED results out.
interface smal_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] angle_0;
  logic [7:0] angle_1;
  logic [7:0] angle_2;
  logic [7:0] angle_3;
  logic [7:0] angle_4;

  modport source (output valid, angle_0, angle_1, angle_2, angle_3, angle_4, input ready);
  modport sink   (input valid, angle_0, angle_1, angle_2, angle_3, angle_4, output ready);
endinterface

interface smal_out_if;
  logic valid;
  logic ready;
  logic led_level;
  logic motion_active;
  logic motion_detected;

  modport source (output valid, led_level, motion_active, motion_detected, input ready);
  modport sink   (input valid, led_level, motion_active, motion_detected, output ready);
endinterface

[sv/smal_cfg.sv]
// Configuration register file for the servo motion activity LED block.
module smal_cfg
  import smal_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [REG_W-1:0]     wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale         <= PRESCALE_RST;
      cfg_r.hold_checks      <= HOLD_RST;
      cfg_r.blink_checks     <= BLINK_RST;
      cfg_r.motion_threshold <= THRESHOLD_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_PRESCALE:  cfg_r.prescale         <= wr_data;
        REG_HOLD:      cfg_r.hold_checks      <= wr_data;
        REG_BLINK:     cfg_r.blink_checks     <= wr_data;
        REG_THRESHOLD: cfg_r.motion_threshold <= wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/smal_core.sv]
// Input register, motion check, activity state and result register.
module smal_core
  import smal_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  angles_t in_angles,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_led,
  output logic    out_active,
  output logic    out_detected
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = (CW > REG_W) ? CW : REG_W;

  logic                  s1_valid_r;
  angles_t               s1_ang_r;
  logic [CW-1:0]         tick_r, tick_nxt;
  angles_t               stored_r, stored_nxt;
  logic                  active_r, active_nxt;
  logic [CW-1:0]         idle_r, idle_nxt;
  logic [CW-1:0]         blink_r, blink_nxt;
  logic                  pin_r, pin_nxt;
  logic                  out_valid_r;
  logic                  out_led_r, out_active_r, out_det_r;

  logic                  adv, take;
  logic [CW-1:0]         tick_inc, idle_inc, blink_inc;
  logic                  check;
  logic [NUM_SERVOS-1:0] moving;
  logic [ANGLE_W-1:0]    diff [NUM_SERVOS];
  logic                  det_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || adv;
  assign take     = s1_valid_r && adv;

  assign tick_inc  = (tick_r  == {CW{1'b1}}) ? tick_r  : tick_r  + CW'(1'b1);
  assign idle_inc  = (idle_r  == {CW{1'b1}}) ? idle_r  : idle_r  + CW'(1'b1);
  assign blink_inc = (blink_r == {CW{1'b1}}) ? blink_r : blink_r + CW'(1'b1);
  assign check     = CMP_W'(tick_inc) >= CMP_W'(cfg.prescale);

  always_comb begin
    for (int i = 0; i < NUM_SERVOS; i++) begin
      diff[i]   = (s1_ang_r[i] > stored_r[i]) ? s1_ang_r[i] - stored_r[i]
                                              : stored_r[i] - s1_ang_r[i];
      moving[i] = diff[i] > cfg.motion_threshold;
    end
  end

  always_comb begin
    tick_nxt   = tick_inc;
    stored_nxt = stored_r;
    active_nxt = active_r;
    idle_nxt   = idle_r;
    blink_nxt  = blink_r;
    pin_nxt    = pin_r;
    det_nxt    = 1'b0;
    if (check) begin
      tick_nxt = '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        if (moving[i]) begin
          stored_nxt[i] = s1_ang_r[i];
        end
      end
      if (|moving) begin
        det_nxt    = 1'b1;
        active_nxt = 1'b1;
        idle_nxt   = '0;
      end else if (active_r) begin
        idle_nxt = idle_inc;
        if (CMP_W'(idle_inc) > CMP_W'(cfg.hold_checks)) begin
          active_nxt = 1'b0;
        end
      end
      if (active_nxt) begin
        blink_nxt = blink_inc;
        if (CMP_W'(blink_inc) >= CMP_W'(cfg.blink_checks)) begin
          blink_nxt = '0;
          pin_nxt   = !pin_r;
        end
      end else begin
        pin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      stored_r    <= '0;
      active_r    <= 1'b0;
      idle_r      <= '0;
      blink_r     <= '0;
      pin_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (take) begin
        tick_r   <= tick_nxt;
        stored_r <= stored_nxt;
        active_r <= active_nxt;
        idle_r   <= idle_nxt;
        blink_r  <= blink_nxt;
        pin_r    <= pin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ang_r <= in_angles;
    end
    if (take) begin
      out_led_r    <= pin_nxt;
      out_active_r <= active_nxt;
      out_det_r    <= det_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_led      = out_led_r;
  assign out_active   = out_active_r;
  assign out_detected = out_det_r;

endmodule

[sv/servo_motion_activity_led_top.sv]
// Top level of the servo motion activity LED block.
//
// in_chan carries one tick request with five servo angles; out_chan returns
// one result request per tick: LED level, activity flag and whether this
// tick's check saw motion. Both channels use valid/ready; a request moves
// at a clock edge with valid and ready high.
// A tick is registered on entry, checked against the stored angles and the
// counters while it sits in the input register, and its result is
// registered at the output when the output register can take it.
// Throughput is one tick per cycle while out_chan.ready stays high; the
// state update loop (stored angles, idle, blink and prescale counters) sets that figure.
// If the receiver stalls, the result register holds and the input register
// takes one more tick; in_chan.ready then falls until out_chan.ready rises.
// Synchronous reset (rst_n low) empties both registers, zeroes the stored
// angles and counters, clears the held LED level and reloads the register
// defaults: prescale 10, hold 200, blink 25, threshold 1.
// cfg_wr_en writes cfg_wr_data to register cfg_index (0 prescale, 1 hold,
// 2 blink, 3 threshold); write only while no tick is in flight.
module servo_motion_activity_led_top
  import smal_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  smal_in_if.sink              in_chan,
  smal_out_if.source           out_chan,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wr_data
);

  cfg_t    cfg;
  angles_t in_angles;

  assign in_angles = {in_chan.angle_4, in_chan.angle_3, in_chan.angle_2,
                      in_chan.angle_1, in_chan.angle_0};

  smal_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .cfg      (cfg)
  );

  smal_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_angles    (in_angles),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_led      (out_chan.led_level),
    .out_active   (out_chan.motion_active),
    .out_detected (out_chan.motion_detected)
  );

endmodule

[sv/smal_checker.sv]
// Port-level checks for the servo motion activity LED block, with its bind.
module smal_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic motion_active,
  input logic motion_detected
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_detect_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && motion_detected |-> motion_active)
    else $error("motion seen but flag clear");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready |=> ##1 out_valid)
    else $error("accepted tick produced no result");

endmodule

bind servo_motion_activity_led_top smal_checker u_smal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .motion_active   (out_chan.motion_active),
  .motion_detected (out_chan.motion_detected)
);
